// File: rtl/bfc_pkg.sv
`default_nettype none

package bfc_pkg;

   // Default sizes of the tape, the token store and the bracket nesting
   localparam int TAPE_DEPTH_DEF = 32768;
   localparam int PROG_DEPTH_DEF = 4096;
   localparam int NEST_DEPTH_DEF = 256;

   // Request opcodes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_FINISH = 2'd1;
   localparam logic [1:0] OP_STEP   = 2'd2;

   // Response status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_CLOSE  = 3'd1;
   localparam logic [2:0] ST_BAD_OPEN   = 3'd2;
   localparam logic [2:0] ST_HALTED     = 3'd3;
   localparam logic [2:0] ST_PROG_FULL  = 3'd4;
   localparam logic [2:0] ST_STACK_FULL = 3'd5;
   localparam logic [2:0] ST_NOT_READY  = 3'd6;

   // Token kinds; NONE marks a skipped character or an empty history
   localparam logic [3:0] K_RIGHT = 4'd0;
   localparam logic [3:0] K_LEFT  = 4'd1;
   localparam logic [3:0] K_INC   = 4'd2;
   localparam logic [3:0] K_DEC   = 4'd3;
   localparam logic [3:0] K_OUT   = 4'd4;
   localparam logic [3:0] K_IN    = 4'd5;
   localparam logic [3:0] K_OPEN  = 4'd6;
   localparam logic [3:0] K_CLOSE = 4'd7;
   localparam logic [3:0] K_NONE  = 4'd8;

   // Source characters of the eight commands
   localparam logic [7:0] CH_RIGHT = 8'h3E;  // '>'
   localparam logic [7:0] CH_LEFT  = 8'h3C;  // '<'
   localparam logic [7:0] CH_INC   = 8'h2B;  // '+'
   localparam logic [7:0] CH_DEC   = 8'h2D;  // '-'
   localparam logic [7:0] CH_OUT   = 8'h2E;  // '.'
   localparam logic [7:0] CH_IN    = 8'h2C;  // ','
   localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
   localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;     // capture the request item
      logic clear;      // write one zero cell of the tape clearing pass
      logic load;       // compile one source character
      logic patch;      // write the partner index into the open token
      logic exec_step;  // execute the fetched token
      logic finish;     // close loading and check brackets
      logic report;     // report without side effects
      logic post;       // load the response register
   } bfc_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_last;  // final cell of the clearing pass
      logic sticky;      // an error is latched
      logic finished;    // loading is closed
      logic halted;      // program counter reached program length
      logic load_patch;  // the pending character is a matched close
      logic out_free;    // response register can take a result
   } bfc_stat_type;

   // Map a source character onto its token kind
   function automatic logic [3:0] kind_of(input logic [7:0] c);
      logic [3:0] k;
      unique case (c)
         CH_RIGHT: k = K_RIGHT;
         CH_LEFT:  k = K_LEFT;
         CH_INC:   k = K_INC;
         CH_DEC:   k = K_DEC;
         CH_OUT:   k = K_OUT;
         CH_IN:    k = K_IN;
         CH_OPEN:  k = K_OPEN;
         CH_CLOSE: k = K_CLOSE;
         default:  k = K_NONE;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// File: rtl/bfc_ram.sv
`default_nettype none

module bfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word with registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/bfc_ctrl.sv
`default_nettype none

module bfc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic [1:0]            req_opcode,
   output logic                       req_tready,
   input  wire bfc_pkg::bfc_stat_type st,
   output bfc_pkg::bfc_cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOAD,
      S_PATCH,
      S_EXEC,
      S_FINISH,
      S_REPORT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   // Sequence each item; results wait for a free response register
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (st.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.accept = 1'b1;
               if (st.sticky) begin
                  state_in = S_REPORT;
               end else begin
                  unique case (req_opcode)
                     bfc_pkg::OP_LOAD:   state_in = st.finished ? S_REPORT : S_LOAD;
                     bfc_pkg::OP_FINISH: state_in = S_FINISH;
                     bfc_pkg::OP_STEP:
                        state_in = (st.finished && !st.halted) ? S_EXEC : S_REPORT;
                     default:            state_in = S_REPORT;
                  endcase
               end
            end
         end
         S_LOAD: begin
            if (st.out_free) begin
               cmd.load = 1'b1;
               if (st.load_patch) begin
                  state_in = S_PATCH;
               end else begin
                  cmd.post = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_PATCH: begin
            if (st.out_free) begin
               cmd.patch = 1'b1;
               cmd.post  = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_EXEC: begin
            if (st.out_free) begin
               cmd.exec_step = 1'b1;
               cmd.post      = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_FINISH: begin
            if (st.out_free) begin
               cmd.finish = 1'b1;
               cmd.post   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_REPORT: begin
            if (st.out_free) begin
               cmd.report = 1'b1;
               cmd.post   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      ready_in = (state_in == S_IDLE);
   end

   // Hold state and the registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

endmodule

`default_nettype wire

// File: rtl/bfc_datapath.sv
`default_nettype none

module bfc_datapath #(
   parameter int TAPE_DEPTH = bfc_pkg::TAPE_DEPTH_DEF,
   parameter int PROG_DEPTH = bfc_pkg::PROG_DEPTH_DEF,
   parameter int NEST_DEPTH = bfc_pkg::NEST_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [1:0]           req_opcode,
   input  wire logic [7:0]           req_char,
   input  wire bfc_pkg::bfc_cmd_type cmd,
   output bfc_pkg::bfc_stat_type     st,
   input  wire logic                 rsp_tready,
   output logic                      rsp_tvalid,
   output logic [2:0]                rsp_status,
   output logic                      rsp_out_valid,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_halted,
   output logic [12:0]               rsp_prog_counter
);

   // Address, count and token widths
   localparam int TW   = $clog2(TAPE_DEPTH);
   localparam int TW1  = TW + 1;
   localparam int PW   = $clog2(PROG_DEPTH);
   localparam int LW   = $clog2(PROG_DEPTH + 1);
   localparam int NAW  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
   localparam int NLW  = $clog2(NEST_DEPTH + 1);
   localparam int DW0  = (TW > PW) ? TW : PW;
   localparam int DW   = (DW0 > 8) ? DW0 : 8;
   localparam int WW   = DW + 3;

   // Item and machine state
   logic [1:0]    op_ff;
   logic [7:0]    char_ff;
   logic [2:0]    sticky_ff, sticky_in;
   logic          finished_ff, finished_in;
   logic [LW-1:0] len_ff, len_in;
   logic [NLW-1:0] level_ff, level_in;
   logic [3:0]    prev_ff, prev_in;
   logic [LW-1:0] pc_ff, pc_in;
   logic [TW-1:0] ptr_ff, ptr_in;
   logic [DW-1:0] last_data_ff, last_data_in;
   logic [PW-1:0] patch_addr_ff, patch_addr_in;
   logic [PW-1:0] patch_slot_ff, patch_slot_in;
   logic [TW-1:0] clr_ff, clr_in;

   // Response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, res_status;
   logic          rsp_ovalid_ff, res_ovalid;
   logic [7:0]    rsp_obyte_ff, res_obyte;
   logic          rsp_halted_ff;
   logic [12:0]   rsp_pc_ff;

   // Memory ports
   logic          prog_we;
   logic [PW-1:0] prog_wa;
   logic [WW-1:0] prog_wd, prog_rd;
   logic          stk_we;
   logic [NAW-1:0] stk_wa, stk_ra;
   logic [PW-1:0] stk_wd, stk_rd;
   logic          tape_we;
   logic [TW-1:0] tape_wa;
   logic [7:0]    tape_wd, tape_rd;

   // Compile-side decode
   logic [3:0]    kind;
   logic          is_cmd, merge, prog_full;
   logic [LW-1:0] len_m1;
   logic [NLW-1:0] level_m1;
   logic [7:0]    add_cnt;
   logic [DW-1:0] merge_data;

   // Execute-side decode
   logic [3:0]    tok_kind;
   logic [DW-1:0] tok_data;
   logic [TW-1:0] mov;
   logic [TW1-1:0] right_sum, left_diff;
   logic [TW-1:0] ptr_right, ptr_left;
   logic [7:0]    cell_inc, cell_dec;
   logic [LW-1:0] pc_next, pc_jump;

   // Memories: program tokens, bracket stack, tape
   bfc_ram #(.WIDTH(WW), .DEPTH(PROG_DEPTH)) u_prog (
      .clock   (clock),
      .wr_en   (prog_we),
      .wr_addr (prog_wa),
      .wr_data (prog_wd),
      .rd_addr (pc_ff[PW-1:0]),
      .rd_data (prog_rd)
   );

   bfc_ram #(.WIDTH(PW), .DEPTH(NEST_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (stk_wd),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   bfc_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
      .clock   (clock),
      .wr_en   (tape_we),
      .wr_addr (tape_wa),
      .wr_data (tape_wd),
      .rd_addr (ptr_ff),
      .rd_data (tape_rd)
   );

   // Decode the pending source character
   always_comb begin
      kind       = bfc_pkg::kind_of(char_ff);
      is_cmd     = (kind != bfc_pkg::K_NONE);
      merge      = (kind <= bfc_pkg::K_DEC) && (kind == prev_ff) && (len_ff != '0);
      prog_full  = (len_ff == LW'(PROG_DEPTH));
      len_m1     = len_ff - LW'(1);
      level_m1   = level_ff - NLW'(1);
      add_cnt    = last_data_ff[7:0] + 8'd1;
      if (kind <= bfc_pkg::K_LEFT) begin
         merge_data = (last_data_ff == DW'(TAPE_DEPTH - 1)) ? '0 : last_data_ff + DW'(1);
      end else begin
         merge_data = DW'(add_cnt);
      end
      stk_ra = level_m1[NAW-1:0];
   end

   // Decode the fetched token and work out pointer, cell and jump
   always_comb begin
      tok_kind  = {1'b0, prog_rd[2:0]};
      tok_data  = prog_rd[WW-1:3];
      mov       = tok_data[TW-1:0];
      right_sum = {1'b0, ptr_ff} + {1'b0, mov};
      left_diff = {1'b0, ptr_ff} - {1'b0, mov};
      if (right_sum >= TW1'(TAPE_DEPTH)) begin
         ptr_right = TW'(right_sum - TW1'(TAPE_DEPTH));
      end else begin
         ptr_right = right_sum[TW-1:0];
      end
      if (left_diff[TW]) begin
         ptr_left = TW'(left_diff + TW1'(TAPE_DEPTH));
      end else begin
         ptr_left = left_diff[TW-1:0];
      end
      cell_inc = tape_rd + tok_data[7:0];
      cell_dec = tape_rd - tok_data[7:0];
      pc_next  = pc_ff + LW'(1);
      pc_jump  = LW'(tok_data[PW-1:0]) + LW'(1);
   end

   // Apply the current command
   always_comb begin
      sticky_in     = sticky_ff;
      finished_in   = finished_ff;
      len_in        = len_ff;
      level_in      = level_ff;
      prev_in       = prev_ff;
      pc_in         = pc_ff;
      ptr_in        = ptr_ff;
      last_data_in  = last_data_ff;
      patch_addr_in = patch_addr_ff;
      patch_slot_in = patch_slot_ff;
      clr_in        = clr_ff;
      prog_we       = 1'b0;
      prog_wa       = len_ff[PW-1:0];
      prog_wd       = {DW'(1), kind[2:0]};
      stk_we        = 1'b0;
      stk_wa        = level_ff[NAW-1:0];
      stk_wd        = len_ff[PW-1:0];
      tape_we       = 1'b0;
      tape_wa       = ptr_ff;
      tape_wd       = 8'd0;
      res_status    = sticky_ff;
      res_ovalid    = 1'b0;
      res_obyte     = 8'd0;

      // Clearing pass over the tape
      if (cmd.clear) begin
         tape_we = 1'b1;
         tape_wa = clr_ff;
         clr_in  = clr_ff + TW'(1);
      end

      // Compile one character
      if (cmd.load && is_cmd) begin
         if (merge) begin
            prog_we      = 1'b1;
            prog_wa      = len_m1[PW-1:0];
            prog_wd      = {merge_data, kind[2:0]};
            last_data_in = merge_data;
         end else if (prog_full) begin
            sticky_in = bfc_pkg::ST_PROG_FULL;
         end else if (kind == bfc_pkg::K_OPEN) begin
            if (level_ff == NLW'(NEST_DEPTH)) begin
               sticky_in = bfc_pkg::ST_STACK_FULL;
            end else begin
               stk_we       = 1'b1;
               level_in     = level_ff + NLW'(1);
               prog_we      = 1'b1;
               len_in       = len_ff + LW'(1);
               prev_in      = kind;
               last_data_in = DW'(1);
            end
         end else if (kind == bfc_pkg::K_CLOSE) begin
            if (level_ff == '0) begin
               sticky_in = bfc_pkg::ST_BAD_CLOSE;
            end else begin
               level_in      = level_m1;
               prog_we       = 1'b1;
               prog_wd       = {DW'(stk_rd), kind[2:0]};
               patch_addr_in = stk_rd;
               patch_slot_in = len_ff[PW-1:0];
               len_in        = len_ff + LW'(1);
               prev_in       = kind;
               last_data_in  = DW'(stk_rd);
            end
         end else begin
            prog_we      = 1'b1;
            len_in       = len_ff + LW'(1);
            prev_in      = kind;
            last_data_in = DW'(1);
         end
         res_status = sticky_in;
      end

      // Point the open bracket at its partner
      if (cmd.patch) begin
         prog_we = 1'b1;
         prog_wa = patch_addr_ff;
         prog_wd = {DW'(patch_slot_ff), bfc_pkg::K_OPEN[2:0]};
      end

      // Close loading
      if (cmd.finish) begin
         if (!finished_ff) begin
            if (level_ff != '0) begin
               sticky_in = bfc_pkg::ST_BAD_OPEN;
            end else begin
               finished_in = 1'b1;
            end
         end
         res_status = sticky_in;
      end

      // Report an item that changes nothing
      if (cmd.report) begin
         if (sticky_ff != bfc_pkg::ST_OK) begin
            res_status = sticky_ff;
         end else if (op_ff == bfc_pkg::OP_STEP) begin
            res_status = finished_ff ? bfc_pkg::ST_HALTED : bfc_pkg::ST_NOT_READY;
         end else begin
            res_status = bfc_pkg::ST_OK;
         end
      end

      // Execute one token
      if (cmd.exec_step) begin
         res_status = bfc_pkg::ST_OK;
         pc_in      = pc_next;
         case (tok_kind)
            bfc_pkg::K_RIGHT: ptr_in = ptr_right;
            bfc_pkg::K_LEFT:  ptr_in = ptr_left;
            bfc_pkg::K_INC: begin
               tape_we = 1'b1;
               tape_wd = cell_inc;
            end
            bfc_pkg::K_DEC: begin
               tape_we = 1'b1;
               tape_wd = cell_dec;
            end
            bfc_pkg::K_OUT: begin
               res_ovalid = 1'b1;
               res_obyte  = tape_rd;
            end
            bfc_pkg::K_IN: begin
               tape_we = 1'b1;
               tape_wd = char_ff;
            end
            bfc_pkg::K_OPEN: begin
               if (tape_rd == 8'd0) begin
                  pc_in = pc_jump;
               end
            end
            default: begin
               if (tape_rd != 8'd0) begin
                  pc_in = pc_jump;
               end
            end
         endcase
      end

      // Response handshake
      if (cmd.post) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sticky_ff    <= bfc_pkg::ST_OK;
         finished_ff  <= 1'b0;
         len_ff       <= '0;
         level_ff     <= '0;
         prev_ff      <= bfc_pkg::K_NONE;
         pc_ff        <= '0;
         ptr_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sticky_ff    <= sticky_in;
         finished_ff  <= finished_in;
         len_ff       <= len_in;
         level_ff     <= level_in;
         prev_ff      <= prev_in;
         pc_ff        <= pc_in;
         ptr_ff       <= ptr_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_opcode;
         char_ff <= req_char;
      end
      last_data_ff  <= last_data_in;
      patch_addr_ff <= patch_addr_in;
      patch_slot_ff <= patch_slot_in;
      if (cmd.post) begin
         rsp_status_ff <= res_status;
         rsp_ovalid_ff <= res_ovalid;
         rsp_obyte_ff  <= res_obyte;
         rsp_halted_ff <= finished_in && (pc_in >= len_in);
         rsp_pc_ff     <= 13'(pc_in);
      end
   end

   // Status to the controller
   always_comb begin
      st.clear_last = (clr_ff == TW'(TAPE_DEPTH - 1));
      st.sticky     = (sticky_ff != bfc_pkg::ST_OK);
      st.finished   = finished_ff;
      st.halted     = finished_ff && (pc_ff >= len_ff);
      st.load_patch = is_cmd && !merge && !prog_full && (kind == bfc_pkg::K_CLOSE)
                      && (level_ff != '0);
      st.out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_valid    = rsp_ovalid_ff;
   assign rsp_out_byte     = rsp_obyte_ff;
   assign rsp_halted       = rsp_halted_ff;
   assign rsp_prog_counter = rsp_pc_ff;

endmodule

`default_nettype wire

// File: rtl/bf_compile_and_execute_core.sv
// Step item: accepted in S_IDLE, result registered in S_EXEC when the response register
// is free, a split set by the registered token and tape reads before the tape write.
// Load item: S_IDLE, S_LOAD; a matched ']' adds S_PATCH, its partner write on the token port.
// Finish and report items: S_FINISH, S_REPORT. The response register lets the next item in.
// Reset (synchronous): a clearing pass zeroes the tape, one cell a cycle, with req_tready low
// throughout; the token and bracket memories are not cleared.
`default_nettype none

module bf_compile_and_execute_core #(
   parameter int TAPE_DEPTH = bfc_pkg::TAPE_DEPTH_DEF,
   parameter int PROG_DEPTH = bfc_pkg::PROG_DEPTH_DEF,
   parameter int NEST_DEPTH = bfc_pkg::NEST_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // char_in
   input  wire logic [1:0]  req_tuser,   // opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // out_valid, out_byte, halted, prog_counter, zero pad
   output logic [2:0]       rsp_tuser    // status
);

   bfc_pkg::bfc_cmd_type  cmd;
   bfc_pkg::bfc_stat_type st;

   logic        out_valid;
   logic [7:0]  out_byte;
   logic        halted;
   logic [12:0] prog_counter;

   bfc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   bfc_datapath #(
      .TAPE_DEPTH (TAPE_DEPTH),
      .PROG_DEPTH (PROG_DEPTH),
      .NEST_DEPTH (NEST_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_tuser),
      .req_char         (req_tdata),
      .cmd              (cmd),
      .st               (st),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_status       (rsp_tuser),
      .rsp_out_valid    (out_valid),
      .rsp_out_byte     (out_byte),
      .rsp_halted       (halted),
      .rsp_prog_counter (prog_counter)
   );

   // Pack the result fields from the lowest bit up
   assign rsp_tdata = {1'b0, prog_counter, halted, out_byte, out_valid};

endmodule

`default_nettype wire
